@@ rtl/sss_pkg.sv @@
// Shared types and constants for the step series statistics block.
package sss_pkg;

    // Widths fixed by the stream and configuration fields
    localparam int STEP_W     = 16;
    localparam int TOTAL_W    = 11;
    localparam int POS_W      = 10;
    localparam int MEAN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RESULT_W   = 72;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CEILING   = 2'd1;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RUN_THRESHOLD_RESET = 16'd500;
    localparam logic [CFG_DATA_W-1:0] MIN_CEILING_RESET   = 16'd10000;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DIVIDE,
        ST_HOLD
    } sss_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // sample request taken this cycle
        logic snap;      // taken sample closes the set: capture summary, clear set
        logic div_step;  // one quotient bit of the mean
        logic out_load;  // move finished summary into the output register
    } sss_cmd_t;

endpackage

@@ rtl/sss_ctrl.sv @@
// Controller: sequences sample intake, mean division and result hand-off.
module sss_ctrl #(
    parameter int STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  logic              m_tready,
    output logic              m_tvalid,
    output sss_pkg::sss_cmd_t cmd
);

    localparam int STEP_CNT_W = $clog2(STEPS);

    sss_pkg::sss_state_t   state_reg;
    sss_pkg::sss_state_t   state_next;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [STEP_CNT_W-1:0] step_next;
    logic                  valid_reg;
    logic                  valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sss_pkg::ST_COLLECT;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            sss_pkg::ST_COLLECT:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    cmd.snap   = 1'b1;
                    step_next  = STEP_CNT_W'(STEPS - 1);
                    state_next = sss_pkg::ST_DIVIDE;
                end
            end
            sss_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = sss_pkg::ST_HOLD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            sss_pkg::ST_HOLD:
            begin
                // wait for the output register to empty
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sss_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = sss_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

@@ rtl/sss_datapath.sv @@
// Datapath: running statistics, configuration registers, mean divider and output register.
module sss_datapath #(
    parameter int MAX_RECORDS = 1024,
    parameter int SAMPLE_W    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sss_pkg::sss_cmd_t                   cmd,
    input  logic [sss_pkg::STEP_W-1:0]          step_count,
    input  logic                                last_sample,
    input  logic                                cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [sss_pkg::RESULT_W-1:0]        result_data,
    output logic                                result_overflowed
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam logic [sss_pkg::STEP_W-1:0] SAMPLE_MASK =
        sss_pkg::STEP_W'((32'd1 << SAMPLE_W) - 32'd1);

    // configuration
    logic [sss_pkg::CFG_DATA_W-1:0] threshold_reg;
    logic [sss_pkg::CFG_DATA_W-1:0] ceiling_reg;

    // running state of the open set
    logic [CNT_W-1:0]          cnt_reg,        cnt_next;
    logic [sss_pkg::STEP_W-1:0] min_value_reg,  min_value_next;
    logic [IDX_W-1:0]          min_pos_reg,    min_pos_next;
    logic [sss_pkg::STEP_W-1:0] max_value_reg,  max_value_next;
    logic [IDX_W-1:0]          max_pos_reg,    max_pos_next;
    logic [SUM_W-1:0]          sum_reg,        sum_next;
    logic                      in_run_reg,     in_run_next;
    logic [IDX_W-1:0]          open_first_reg, open_first_next;
    logic [IDX_W-1:0]          open_last_reg,  open_last_next;
    logic [IDX_W-1:0]          best_first_reg, best_first_next;
    logic [IDX_W-1:0]          best_last_reg,  best_last_next;
    logic                      dropped_reg,    dropped_next;

    // captured summary and divider
    logic [CNT_W-1:0]    job_total_reg;
    logic [IDX_W-1:0]    job_fewest_reg;
    logic [IDX_W-1:0]    job_largest_reg;
    logic [IDX_W-1:0]    job_first_reg;
    logic [IDX_W-1:0]    job_last_reg;
    logic                job_dropped_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0] quo_reg;

    // output register
    logic [sss_pkg::RESULT_W-1:0] out_data_reg;
    logic                         out_overflowed_reg;

    logic [sss_pkg::STEP_W-1:0] sample;
    logic                       counted;
    logic [IDX_W-1:0]           idx;
    logic [sss_pkg::STEP_W-1:0] min_cur;
    logic                       new_min;
    logic                       new_max;
    logic                       above;
    logic                       commit;
    logic                       longer;

    logic [CNT_W:0]   trial;
    logic             fits;

    logic [31:0] total_ext;
    logic [31:0] fewest_ext;
    logic [31:0] largest_ext;
    logic [31:0] mean_ext;
    logic [31:0] first_ext;
    logic [31:0] last_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sss_pkg::RUN_THRESHOLD_RESET;
            ceiling_reg   <= sss_pkg::MIN_CEILING_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sss_pkg::REG_RUN_THRESHOLD)
            begin
                threshold_reg <= cfg_data;
            end
            else if (cfg_index == sss_pkg::REG_MIN_CEILING)
            begin
                ceiling_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        sample  = step_count & SAMPLE_MASK;
        counted = cnt_reg < CNT_W'(MAX_RECORDS);
        idx     = cnt_reg[IDX_W-1:0];
        // the ceiling stands in for the minimum at the first sample of a set
        min_cur = (cnt_reg == '0) ? ceiling_reg : min_value_reg;
        new_min = counted && (sample < min_cur);
        new_max = counted && (sample > max_value_reg);
        above   = sample > threshold_reg;

        min_value_next = counted ? (new_min ? sample : min_cur) : min_value_reg;
        min_pos_next   = new_min ? idx : min_pos_reg;
        max_value_next = new_max ? sample : max_value_reg;
        max_pos_next   = new_max ? idx : max_pos_reg;
        sum_next       = counted ? sum_reg + SUM_W'(sample) : sum_reg;
        cnt_next       = counted ? cnt_reg + 1'b1 : cnt_reg;
        dropped_next   = dropped_reg | ~counted;

        open_first_next = open_first_reg;
        open_last_next  = open_last_reg;
        in_run_next     = in_run_reg;
        if (counted && above)
        begin
            open_first_next = in_run_reg ? open_first_reg : idx;
            open_last_next  = idx;
            in_run_next     = 1'b1;
        end
        else if (counted)
        begin
            in_run_next = 1'b0;
        end

        // close a run on a low sample, or one still open at the end of the set
        commit = counted ? (above ? last_sample : in_run_reg) : (last_sample && in_run_reg);
        longer = (open_last_next - open_first_next) > (best_last_reg - best_first_reg);
        best_first_next = (commit && longer) ? open_first_next : best_first_reg;
        best_last_next  = (commit && longer) ? open_last_next  : best_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            min_value_reg  <= sss_pkg::MIN_CEILING_RESET;
            min_pos_reg    <= '0;
            max_value_reg  <= '0;
            max_pos_reg    <= '0;
            sum_reg        <= '0;
            in_run_reg     <= 1'b0;
            open_first_reg <= '0;
            open_last_reg  <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            dropped_reg    <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (cmd.snap)
            begin
                cnt_reg        <= '0;
                min_value_reg  <= ceiling_reg;
                min_pos_reg    <= '0;
                max_value_reg  <= '0;
                max_pos_reg    <= '0;
                sum_reg        <= '0;
                in_run_reg     <= 1'b0;
                open_first_reg <= '0;
                open_last_reg  <= '0;
                best_first_reg <= '0;
                best_last_reg  <= '0;
                dropped_reg    <= 1'b0;
            end
            else
            begin
                cnt_reg        <= cnt_next;
                min_value_reg  <= min_value_next;
                min_pos_reg    <= min_pos_next;
                max_value_reg  <= max_value_next;
                max_pos_reg    <= max_pos_next;
                sum_reg        <= sum_next;
                in_run_reg     <= in_run_next;
                open_first_reg <= open_first_next;
                open_last_reg  <= open_last_next;
                best_first_reg <= best_first_next;
                best_last_reg  <= best_last_next;
                dropped_reg    <= dropped_next;
            end
        end
    end

    // restoring divider: the sum is below count * 2^SAMPLE_W, so the
    // upper part already sits below the divisor and SAMPLE_W steps suffice
    always_comb
    begin
        trial = {rem_reg, quo_reg[SAMPLE_W-1]};
        fits  = trial >= {1'b0, job_total_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            job_total_reg   <= cnt_next;
            job_fewest_reg  <= min_pos_next;
            job_largest_reg <= max_pos_next;
            job_first_reg   <= best_first_next;
            job_last_reg    <= best_last_next;
            job_dropped_reg <= dropped_next;
            rem_reg         <= sum_next[SUM_W-1:SAMPLE_W];
            quo_reg         <= sum_next[SAMPLE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, job_total_reg}) : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[SAMPLE_W-2:0], fits};
        end
    end

    always_comb
    begin
        total_ext   = 32'(job_total_reg);
        fewest_ext  = 32'(job_fewest_reg);
        largest_ext = 32'(job_largest_reg);
        mean_ext    = (job_total_reg == '0) ? 32'd0 : 32'(quo_reg);
        first_ext   = 32'(job_first_reg);
        last_ext    = 32'(job_last_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {5'd0,
                             last_ext[sss_pkg::POS_W-1:0],
                             first_ext[sss_pkg::POS_W-1:0],
                             mean_ext[sss_pkg::MEAN_W-1:0],
                             largest_ext[sss_pkg::POS_W-1:0],
                             fewest_ext[sss_pkg::POS_W-1:0],
                             total_ext[sss_pkg::TOTAL_W-1:0]};
            out_overflowed_reg <= job_dropped_reg;
        end
    end

    assign result_data       = out_data_reg;
    assign result_overflowed = out_overflowed_reg;

endmodule

@@ rtl/step_series_statistics.sv @@
// Step series statistics: minimum, maximum, mean and longest run over sets of samples.
// Samples are taken one per cycle while a set is collected. The sample carrying tlast
// closes the set: the block then stops taking samples while a shift-subtract divider
// forms the mean at one quotient bit per cycle, and the next request is taken only once
// the summary has moved into the output register, where it waits;
// samples of the next set are taken meanwhile, and so is its closing sample, but after
// that division intake stays paused until the previous summary has been taken. Samples
// past MAX_RECORDS in a set are dropped and reported through m_tuser. Configuration is
// written through the cfg channel, which is always ready; index 0 is the run threshold,
// index 1 the minimum ceiling.
module step_series_statistics #(
    parameter int MAX_RECORDS = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] step_count
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] record_total, [20:11] fewest_index, [30:21] largest_index,
    // [46:31] mean_steps, [56:47] run_start, [66:57] run_end, [71:67] zero
    output logic [71:0] m_tdata,
    output logic        m_tuser,   // overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SAMPLE_W = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

    sss_pkg::sss_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sss_ctrl #(
        .STEPS (SAMPLE_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    sss_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .SAMPLE_W    (SAMPLE_W)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .step_count        (s_tdata),
        .last_sample       (s_tlast),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result_data       (m_tdata),
        .result_overflowed (m_tuser)
    );

endmodule

@@ rtl/sss_checker.sv @@
// Port-level checks for the step series statistics block, bound to the top level.
module sss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // a stalled summary stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("summary withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("summary changed while stalled");

    // closing a set starts the mean division, so intake pauses
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("sample taken during mean division");

    // a new summary is only loaded while intake is paused
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("summary appeared without a division");

endmodule

bind step_series_statistics sss_checker u_checker (.*);
